### src/rqop_pkg.sv
// Shared types and constants of the overload-managed request queue.
// Used by rqop_cfg, rqop_mod and request_queue_overload_policy_core; no dependencies.
package rqop_pkg;

	localparam int ID_W   = 16;
	localparam int TIME_W = 32;
	localparam int ENT_W  = ID_W + TIME_W;
	localparam int LFSR_W = 16;
	localparam int ACT_W  = 16;

	localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
	localparam logic [LFSR_W-1:0] SEED_RST  = 16'h0001;
	localparam logic [5:0]        CAP_RST   = 6'd32;

	// Operation codes.
	localparam logic [1:0] OP_ENQ  = 2'd0;
	localparam logic [1:0] OP_DEQ  = 2'd1;
	localparam logic [1:0] OP_DONE = 2'd2;

	// Overload policies.
	localparam logic [1:0] POL_BLOCK = 2'd0;
	localparam logic [1:0] POL_TAIL  = 2'd1;
	localparam logic [1:0] POL_HEAD  = 2'd2;
	localparam logic [1:0] POL_RAND  = 2'd3;

	// Result kinds.
	localparam logic [2:0] K_ACCEPT = 3'd0;
	localparam logic [2:0] K_FULL   = 3'd1;
	localparam logic [2:0] K_CLOSED = 3'd2;
	localparam logic [2:0] K_DEQ    = 3'd3;
	localparam logic [2:0] K_EMPTY  = 3'd4;
	localparam logic [2:0] K_DONE   = 3'd5;

	// Register indexes.
	localparam logic [1:0] REG_POLICY   = 2'd0;
	localparam logic [1:0] REG_CAPACITY = 2'd1;
	localparam logic [1:0] REG_SEED     = 2'd2;

	typedef struct packed {
		logic [1:0]        policy;
		logic [5:0]        capacity;
		logic              seed_ld;
		logic [LFSR_W-1:0] seed;
	} cfg_t;

	// One step of the right-shifting Galois LFSR; the all-zero state is replaced by one.
	function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
		logic [LFSR_W-1:0] n;
		n = v >> 1;
		if (v[0]) begin
			n = n ^ LFSR_TAPS;
		end
		if (n == '0) begin
			n = SEED_RST;
		end
		return n;
	endfunction

endpackage

### src/request_queue_overload_policy_core.sv
// Request queue with overload policy: entry memory, drop-mark memory and control sequencer.
// Depends on rqop_pkg, rqop_cfg and rqop_mod.
//
// A ring of QUEUE_DEPTH waiting requests held in a single-port-write, registered-read memory.
// Enqueue without overload, done, full-retry and tail drop are answered in the idle state.
// Dequeue and drop head first read the head entry; drop head then reports the accepted word.
// Random drop of n waiting entries runs one item at a time: it clears the mark memory over n
// entries, then makes ceil(n/2) draws plus redraws on already marked entries, each draw an LFSR
// step, a pass through the remainder unit and a mark read; then it reads each entry to compact
// the ring and report closed entries, and reports the accepted word. No input is taken meanwhile.
// Output stalls can hold every path. There is no clearing pass after reset.
module request_queue_overload_policy_core #(
	parameter int QUEUE_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [15:0] request_id,
	input  logic [31:0] arrival_time,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [15:0] out_id,
	output logic [31:0] out_time,
	output logic        last
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int EW = rqop_pkg::ENT_W;
	localparam int NW = rqop_pkg::ACT_W;
	localparam int SW = rqop_pkg::ACT_W + 1;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_HEAD = 9'b000000010,
		ST_ACC  = 9'b000000100,
		ST_CLR  = 9'b000001000,
		ST_PICK = 9'b000010000,
		ST_DIV  = 9'b000100000,
		ST_MCHK = 9'b001000000,
		ST_WRD  = 9'b010000000,
		ST_WCHK = 9'b100000000
	} st_t;

	function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [CW-1:0] off);
		logic [CW:0] s;
		s = {{(CW + 1 - AW){1'b0}}, base} + {1'b0, off};
		if (s >= (CW + 1)'(QUEUE_DEPTH)) begin
			s = s - (CW + 1)'(QUEUE_DEPTH);
		end
		return s[AW-1:0];
	endfunction

	rqop_pkg::cfg_t cfg;

	rqop_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	st_t                          st_q, st_d;
	logic [AW-1:0]                head_q, head_d;
	logic [CW-1:0]                wait_q, wait_d;
	logic [rqop_pkg::ACT_W-1:0]   act_q, act_d;
	logic [rqop_pkg::LFSR_W-1:0]  lfsr_q, lfsr_d;
	logic [CW-1:0]                idx_q, idx_d;
	logic [CW-1:0]                kept_q, kept_d;
	logic [CW-1:0]                pc_q, pc_d;
	logic [CW-1:0]                drops_q, drops_d;
	logic [CW-1:0]                cnt_q, cnt_d;
	logic                         dq_q, dq_d;
	logic [AW-1:0]                cand_q, cand_d;
	logic [rqop_pkg::ID_W-1:0]    nid_q;
	logic [rqop_pkg::TIME_W-1:0]  ntm_q;

	logic                         ov_q;
	logic [2:0]                   kind_q;
	logic [15:0]                  id_q;
	logic [31:0]                  tm_q;
	logic                         last_q;

	logic                         out_free, acc;
	logic                         em;
	logic [2:0]                   em_kind;
	logic [15:0]                  em_id;
	logic [31:0]                  em_tm;
	logic                         em_last;

	logic [EW-1:0]                ent_mem [QUEUE_DEPTH];
	logic [EW-1:0]                ent_rd_q, ent_wd;
	logic                         ent_we, ent_re;
	logic [AW-1:0]                ent_wa, ent_ra;
	logic                         mk_mem [QUEUE_DEPTH];
	logic                         mk_rd_q, mk_wd, mk_we, mk_re;
	logic [AW-1:0]                mk_wa, mk_ra;

	logic                         div_start, div_done;
	logic [CW-1:0]                div_rem;
	logic [SW-1:0]                used, capf, cap_ext;
	logic                         full;
	logic [CW:0]                  wait_p1;
	logic [CW-1:0]                kept_nx;

	rqop_mod #(.DW(CW)) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (lfsr_d),
		.divisor  (cnt_q),
		.done     (div_done),
		.rem      (div_rem)
	);

	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[ent_wa] <= ent_wd;
		end
		if (ent_re) begin
			ent_rd_q <= ent_mem[ent_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (mk_we) begin
			mk_mem[mk_wa] <= mk_wd;
		end
		if (mk_re) begin
			mk_rd_q <= mk_mem[mk_ra];
		end
	end

	assign out_free = !ov_q || !out_stall;
	assign in_stall = !((st_q == ST_IDLE) && out_free);
	assign acc      = in_valid && !in_stall;

	always_comb begin
		cap_ext = SW'(cfg.capacity);
		capf    = (cap_ext > SW'(QUEUE_DEPTH)) ? SW'(QUEUE_DEPTH) : cap_ext;
		used    = {1'b0, act_q} + SW'(wait_q);
		full    = (used >= capf) || (wait_q >= CW'(QUEUE_DEPTH));
		wait_p1 = {1'b0, wait_q} + (CW + 1)'(1);
	end

	always_comb begin
		st_d      = st_q;
		head_d    = head_q;
		wait_d    = wait_q;
		act_d     = act_q;
		lfsr_d    = lfsr_q;
		idx_d     = idx_q;
		kept_d    = kept_q;
		pc_d      = pc_q;
		drops_d   = drops_q;
		cnt_d     = cnt_q;
		dq_d      = dq_q;
		cand_d    = cand_q;
		em        = 1'b0;
		em_kind   = rqop_pkg::K_ACCEPT;
		em_id     = '0;
		em_tm     = '0;
		em_last   = 1'b1;
		ent_we    = 1'b0;
		ent_wa    = slot(head_q, wait_q);
		ent_wd    = {nid_q, ntm_q};
		ent_re    = 1'b0;
		ent_ra    = head_q;
		mk_we     = 1'b0;
		mk_wa     = idx_q[AW-1:0];
		mk_wd     = 1'b0;
		mk_re     = 1'b0;
		mk_ra     = idx_q[AW-1:0];
		div_start = 1'b0;
		kept_nx   = kept_q;

		case (st_q)
			ST_IDLE: begin
				if (acc) begin
					case (op)
						rqop_pkg::OP_ENQ: begin
							if (!full) begin
								ent_we  = 1'b1;
								ent_wd  = {request_id, arrival_time};
								wait_d  = wait_p1[CW-1:0];
								em      = 1'b1;
								em_kind = rqop_pkg::K_ACCEPT;
								em_id   = request_id;
								em_tm   = arrival_time;
							end else if (cfg.policy == rqop_pkg::POL_BLOCK) begin
								em      = 1'b1;
								em_kind = rqop_pkg::K_FULL;
								em_id   = request_id;
								em_tm   = arrival_time;
							end else if (cfg.policy == rqop_pkg::POL_TAIL || wait_q == '0) begin
								em      = 1'b1;
								em_kind = rqop_pkg::K_CLOSED;
								em_id   = request_id;
								em_tm   = arrival_time;
							end else if (cfg.policy == rqop_pkg::POL_HEAD) begin
								ent_re = 1'b1;
								dq_d   = 1'b0;
								st_d   = ST_HEAD;
							end else begin
								cnt_d   = wait_q;
								drops_d = wait_p1[CW:1];
								idx_d   = '0;
								st_d    = ST_CLR;
							end
						end
						rqop_pkg::OP_DEQ: begin
							if (wait_q == '0) begin
								em      = 1'b1;
								em_kind = rqop_pkg::K_EMPTY;
							end else begin
								ent_re = 1'b1;
								dq_d   = 1'b1;
								st_d   = ST_HEAD;
							end
						end
						rqop_pkg::OP_DONE: begin
							if (act_q != '0) begin
								act_d = act_q - NW'(1);
							end
							em      = 1'b1;
							em_kind = rqop_pkg::K_DONE;
							em_id   = request_id;
						end
						default: ;
					endcase
				end
			end
			ST_HEAD: begin
				if (out_free) begin
					em      = 1'b1;
					em_kind = dq_q ? rqop_pkg::K_DEQ : rqop_pkg::K_CLOSED;
					em_id   = ent_rd_q[EW-1:rqop_pkg::TIME_W];
					em_tm   = ent_rd_q[rqop_pkg::TIME_W-1:0];
					em_last = dq_q;
					head_d  = slot(head_q, CW'(1));
					wait_d  = wait_q - CW'(1);
					if (dq_q) begin
						if (act_q != '1) begin
							act_d = act_q + NW'(1);
						end
						st_d = ST_IDLE;
					end else begin
						st_d = ST_ACC;
					end
				end
			end
			ST_ACC: begin
				if (out_free) begin
					ent_we  = 1'b1;
					wait_d  = wait_p1[CW-1:0];
					em      = 1'b1;
					em_kind = rqop_pkg::K_ACCEPT;
					em_id   = nid_q;
					em_tm   = ntm_q;
					st_d    = ST_IDLE;
				end
			end
			ST_CLR: begin
				mk_we = 1'b1;
				if (idx_q == cnt_q - CW'(1)) begin
					pc_d = '0;
					st_d = ST_PICK;
				end else begin
					idx_d = idx_q + CW'(1);
				end
			end
			ST_PICK: begin
				lfsr_d    = rqop_pkg::lfsr_next(lfsr_q);
				div_start = 1'b1;
				st_d      = ST_DIV;
			end
			ST_DIV: begin
				if (div_done) begin
					mk_re  = 1'b1;
					mk_ra  = div_rem[AW-1:0];
					cand_d = div_rem[AW-1:0];
					st_d   = ST_MCHK;
				end
			end
			ST_MCHK: begin
				if (mk_rd_q) begin
					st_d = ST_PICK;
				end else begin
					mk_we = 1'b1;
					mk_wa = cand_q;
					mk_wd = 1'b1;
					if (pc_q + CW'(1) == drops_q) begin
						idx_d  = '0;
						kept_d = '0;
						st_d   = ST_WRD;
					end else begin
						pc_d = pc_q + CW'(1);
						st_d = ST_PICK;
					end
				end
			end
			ST_WRD: begin
				ent_re = 1'b1;
				ent_ra = slot(head_q, idx_q);
				mk_re  = 1'b1;
				st_d   = ST_WCHK;
			end
			ST_WCHK: begin
				// Kept entries slide toward the head; the write never reaches an unread slot.
				if (!mk_rd_q || out_free) begin
					if (mk_rd_q) begin
						em      = 1'b1;
						em_kind = rqop_pkg::K_CLOSED;
						em_id   = ent_rd_q[EW-1:rqop_pkg::TIME_W];
						em_tm   = ent_rd_q[rqop_pkg::TIME_W-1:0];
						em_last = 1'b0;
					end else begin
						ent_we  = 1'b1;
						ent_wa  = slot(head_q, kept_q);
						ent_wd  = ent_rd_q;
						kept_nx = kept_q + CW'(1);
					end
					kept_d = kept_nx;
					if (idx_q == cnt_q - CW'(1)) begin
						wait_d = kept_nx;
						st_d   = ST_ACC;
					end else begin
						idx_d = idx_q + CW'(1);
						st_d  = ST_WRD;
					end
				end
			end
			default: st_d = ST_IDLE;
		endcase

		if (cfg.seed_ld) begin
			lfsr_d = cfg.seed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			head_q  <= '0;
			wait_q  <= '0;
			act_q   <= '0;
			lfsr_q  <= rqop_pkg::SEED_RST;
			idx_q   <= '0;
			kept_q  <= '0;
			pc_q    <= '0;
			drops_q <= '0;
			cnt_q   <= '0;
			dq_q    <= 1'b0;
			cand_q  <= '0;
			ov_q    <= 1'b0;
		end else begin
			st_q    <= st_d;
			head_q  <= head_d;
			wait_q  <= wait_d;
			act_q   <= act_d;
			lfsr_q  <= lfsr_d;
			idx_q   <= idx_d;
			kept_q  <= kept_d;
			pc_q    <= pc_d;
			drops_q <= drops_d;
			cnt_q   <= cnt_d;
			dq_q    <= dq_d;
			cand_q  <= cand_d;
			if (em) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			nid_q <= request_id;
			ntm_q <= arrival_time;
		end
		if (em) begin
			kind_q <= em_kind;
			id_q   <= em_id;
			tm_q   <= em_tm;
			last_q <= em_last;
		end
	end

	assign out_valid = ov_q;
	assign kind      = kind_q;
	assign out_id    = id_q;
	assign out_time  = tm_q;
	assign last      = last_q;

endmodule

### src/rqop_cfg.sv
// APB-style configuration registers: policy, capacity and LFSR seed.
// Depends on rqop_pkg.
module rqop_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output rqop_pkg::cfg_t      cfg
);

	logic [1:0]                  policy_q;
	logic [5:0]                  cap_q;
	logic [rqop_pkg::LFSR_W-1:0] seed_q;
	logic                        wr;
	logic [1:0]                  idx;

	assign pready = 1'b1;
	assign idx    = paddr[3:2];
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= rqop_pkg::POL_BLOCK;
			cap_q    <= rqop_pkg::CAP_RST;
			seed_q   <= rqop_pkg::SEED_RST;
		end else if (wr) begin
			case (idx)
				rqop_pkg::REG_POLICY:   policy_q <= pwdata[1:0];
				rqop_pkg::REG_CAPACITY: cap_q    <= pwdata[5:0];
				rqop_pkg::REG_SEED:     seed_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			rqop_pkg::REG_POLICY:   prdata = {30'd0, policy_q};
			rqop_pkg::REG_CAPACITY: prdata = {26'd0, cap_q};
			rqop_pkg::REG_SEED:     prdata = {16'd0, seed_q};
			default:                prdata = '0;
		endcase
	end

	always_comb begin
		cfg.policy   = policy_q;
		cfg.capacity = cap_q;
		cfg.seed_ld  = wr && (idx == rqop_pkg::REG_SEED);
		cfg.seed     = (pwdata[15:0] == '0) ? rqop_pkg::SEED_RST : pwdata[15:0];
	end

endmodule

### src/rqop_mod.sv
// Restoring remainder unit: 16-bit dividend modulo a narrow divisor, one bit per cycle.
// Depends on rqop_pkg.
module rqop_mod #(
	parameter int DW = 6
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [rqop_pkg::LFSR_W-1:0] dividend,
	input  logic [DW-1:0]               divisor,
	output logic                        done,
	output logic [DW-1:0]               rem
);

	logic [rqop_pkg::LFSR_W-1:0] dvd_q;
	logic [DW-1:0]               dvs_q;
	logic [DW-1:0]               rem_q;
	logic [4:0]                  n_q;
	logic                        done_q;
	logic [DW:0]                 t;
	logic [DW:0]                 t_sub;

	always_comb begin
		t     = {rem_q, dvd_q[rqop_pkg::LFSR_W-1]};
		t_sub = (t >= {1'b0, dvs_q}) ? (t - {1'b0, dvs_q}) : t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q    <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			n_q    <= 5'(rqop_pkg::LFSR_W);
			done_q <= 1'b0;
		end else if (n_q != '0) begin
			n_q    <= n_q - 5'd1;
			done_q <= (n_q == 5'd1);
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (n_q != '0) begin
			dvd_q <= dvd_q << 1;
			rem_q <= t_sub[DW-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule
